// File: rtl/sqe_pkg.sv
package sqe_pkg;

    // Operation codes carried in the slave-side tuser.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_PRINT = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_POP   = 3'd3;
    localparam logic [2:0] OP_SWAP  = 3'd4;

    // Status codes carried in the master-side tuser.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_SHORT       = 3'd2;
    localparam logic [2:0] ST_FULL        = 3'd3;
    localparam logic [2:0] ST_PRINT_EMPTY = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP_B,
        S_SWAP_W
    } t_state;

endpackage

// File: rtl/sqe_ram.sv
module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; read data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/stack_queue_engine_unit.sv
// Sequence: push, pop, peek and the refused cases fetch the top when the input beat is
// taken and give the result beat from S_EXEC; swap also passes S_SWAP_B and S_SWAP_W, as
// it needs two reads and two writes on the RAM ports; print all gives one beat per stored
// element, paced by the registered read. Input beats are taken only in S_IDLE, once the
// last operation is through; an output register lets the next one in while a result waits.
// Reset (synchronous, active low) clears the front pointer, count, mode, sequencer and output valid only.
module stack_queue_engine_unit
    import sqe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: queue_mode.
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] op
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] read_value
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X   = (PW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_state        r_state, n_state;
    logic          r_queue_mode;
    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_op, n_op;
    logic [31:0]   r_val, n_val;
    logic [31:0]   r_tmp, n_tmp;
    logic [PW-1:0] r_idx, n_idx;

    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_data, n_out_data;
    logic [2:0]    r_out_status, n_out_status;
    logic          r_out_last, n_out_last;

    logic          w_accept;
    logic          w_out_free;
    logic          w_we, w_re;
    logic [PW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;

    logic [PW-1:0] w_slot1;
    logic [PW-1:0] w_prev_front;
    logic [PW-1:0] w_next_k;
    logic [PW:0]   w_print_sum, w_tail_sum;
    logic [PW-1:0] w_print_addr, w_tail_addr;
    logic          w_print_last;

    sqe_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // Circular slot arithmetic: one compare and subtract keeps each sum below the depth.
    assign w_slot1      = (r_front == LAST_SLOT) ? '0 : r_front + PW'(1);
    assign w_prev_front = (r_front == '0) ? LAST_SLOT : r_front - PW'(1);
    assign w_next_k     = r_idx + PW'(1);
    assign w_print_sum  = {1'b0, r_front} + {1'b0, w_next_k};
    assign w_print_addr = (w_print_sum >= DEPTH_X) ? PW'(w_print_sum - DEPTH_X)
                                                   : PW'(w_print_sum);
    assign w_tail_sum   = {1'b0, r_front} + {1'b0, r_count[PW-1:0]};
    assign w_tail_addr  = (w_tail_sum >= DEPTH_X) ? PW'(w_tail_sum - DEPTH_X)
                                                  : PW'(w_tail_sum);
    assign w_print_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // Sequencer: next state, RAM accesses and result beats.
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_op         = r_op;
        n_val        = r_val;
        n_tmp        = r_tmp;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_waddr      = r_front;
        w_wdata      = r_val;
        w_re         = 1'b0;
        w_raddr      = r_front;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_s_axis_tuser;
                    n_val = i_s_axis_tdata;
                    n_idx = '0;
                    // Fetch the top for the operations that read it; unused codes are dropped.
                    w_re  = 1'b1;
                    if (i_s_axis_tuser <= OP_SWAP) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_PUSH: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                            if (r_count == FULL_CNT) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                w_we         = 1'b1;
                                n_count      = r_count + CW'(1);
                                if (r_queue_mode) begin
                                    w_waddr = w_tail_addr;
                                end else begin
                                    w_waddr = w_prev_front;
                                    n_front = w_prev_front;
                                end
                            end
                        end
                    end
                    OP_PEEK: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                            if (r_count == '0) begin
                                n_out_data   = '0;
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_data   = w_rdata;
                                n_out_status = ST_OK;
                            end
                        end
                    end
                    OP_POP: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_status = ST_OK;
                                n_front      = w_slot1;
                                n_count      = r_count - CW'(1);
                            end
                        end
                    end
                    OP_SWAP: begin
                        if (r_count < CW'(2)) begin
                            if (w_out_free) begin
                                n_out_valid  = 1'b1;
                                n_out_data   = '0;
                                n_out_status = ST_SHORT;
                                n_out_last   = 1'b1;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            // Keep the top value and fetch the one beneath it.
                            n_tmp   = w_rdata;
                            w_re    = 1'b1;
                            w_raddr = w_slot1;
                            n_state = S_SWAP_B;
                        end
                    end
                    OP_PRINT: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_out_data   = '0;
                                n_out_status = ST_PRINT_EMPTY;
                                n_out_last   = 1'b1;
                                n_state      = S_IDLE;
                            end else begin
                                // Emit the fetched element and fetch the next one down.
                                n_out_data   = w_rdata;
                                n_out_status = ST_OK;
                                n_out_last   = w_print_last;
                                if (w_print_last) begin
                                    n_state = S_IDLE;
                                end else begin
                                    n_idx   = w_next_k;
                                    w_re    = 1'b1;
                                    w_raddr = w_print_addr;
                                end
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SWAP_B: begin
                // The second value goes to the top slot.
                w_we    = 1'b1;
                w_waddr = r_front;
                w_wdata = w_rdata;
                n_state = S_SWAP_W;
            end
            S_SWAP_W: begin
                // The old top goes beneath it, together with the result beat.
                if (w_out_free) begin
                    w_we         = 1'b1;
                    w_waddr      = w_slot1;
                    w_wdata      = r_tmp;
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_status = ST_OK;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_queue_mode <= 1'b0;
            r_front      <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front      <= n_front;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_queue_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_tmp        <= n_tmp;
        r_idx        <= n_idx;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

endmodule

// File: test/stack_queue_engine_checker.sv
module stack_queue_engine_checker
    import sqe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] push_value
    input  logic [2:0]  i_s_tuser,    // [2:0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // [31:0] read_value
    input  logic [2:0]  i_m_tuser,    // [2:0] status
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
        logic        last;
    } t_result_beat;

    // Shadow copy of the block's store and pointers.
    logic [31:0]  held_values [DEPTH];
    int           top_slot   = 0;
    int           fill_level = 0;
    logic         queue_mode = 1'b0;

    t_result_beat due_beats [$];
    t_result_beat want;
    int           mismatches = 0;
    int           beats_seen = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_beats      = 0;
    end

    // Apply one operation to the shadow store and queue the beats it should produce.
    task automatic predict_results(input logic [2:0] op, input logic [31:0] value);
        int a;
        int b;
        logic [31:0] t;
        case (op)
            OP_PUSH: begin
                if (fill_level >= DEPTH) begin
                    due_beats.push_back('{32'h0, ST_FULL, 1'b1});
                end else begin
                    if (queue_mode) begin
                        held_values[(top_slot + fill_level) % DEPTH] = value;
                    end else begin
                        top_slot = (top_slot + DEPTH - 1) % DEPTH;
                        held_values[top_slot] = value;
                    end
                    fill_level++;
                    due_beats.push_back('{32'h0, ST_OK, 1'b1});
                end
            end
            OP_PRINT: begin
                if (fill_level == 0) begin
                    due_beats.push_back('{32'h0, ST_PRINT_EMPTY, 1'b1});
                end else begin
                    for (int k = 0; k < fill_level; k++) begin
                        due_beats.push_back('{held_values[(top_slot + k) % DEPTH], ST_OK,
                                              1'(k == fill_level - 1)});
                    end
                end
            end
            OP_PEEK: begin
                if (fill_level == 0) begin
                    due_beats.push_back('{32'h0, ST_EMPTY, 1'b1});
                end else begin
                    due_beats.push_back('{held_values[top_slot], ST_OK, 1'b1});
                end
            end
            OP_POP: begin
                if (fill_level == 0) begin
                    due_beats.push_back('{32'h0, ST_EMPTY, 1'b1});
                end else begin
                    top_slot = (top_slot + 1) % DEPTH;
                    fill_level--;
                    due_beats.push_back('{32'h0, ST_OK, 1'b1});
                end
            end
            OP_SWAP: begin
                if (fill_level < 2) begin
                    due_beats.push_back('{32'h0, ST_SHORT, 1'b1});
                end else begin
                    a = top_slot;
                    b = (top_slot + 1) % DEPTH;
                    t = held_values[a];
                    held_values[a] = held_values[b];
                    held_values[b] = t;
                    due_beats.push_back('{32'h0, ST_OK, 1'b1});
                end
            end
            default: begin
                // Spare opcodes leave everything untouched and give no beat.
            end
        endcase
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            top_slot   = 0;
            fill_level = 0;
            queue_mode = 1'b0;
            due_beats.delete();
        end else begin
            // Results are checked first; none can belong to an input taken at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                beats_seen++;
                if (due_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result beat: value %h status %0d last %b",
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                    end
                end else begin
                    want = due_beats.pop_front();
                    if (i_m_tdata !== want.value || i_m_tuser !== want.status ||
                        i_m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Beat %0d: expected value %h status %0d last %b,",
                                     beats_seen, want.value, want.status, want.last);
                            $display("         got value %h status %0d last %b",
                                     i_m_tdata, i_m_tuser, i_m_tlast);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_results(i_s_tuser, i_s_tdata);
            end
            if (i_cfg_we) begin
                queue_mode = i_cfg_wdata;
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= due_beats.size();
        o_beats      <= beats_seen;
    end

endmodule

// File: test/tb_stack_queue_engine_unit.sv
module tb_stack_queue_engine_unit
    import sqe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    // Opcodes the block does not define; it should ignore them.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [31:0] in_data   = 32'h0;
    logic [2:0]  in_user   = OP_PUSH;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_data;
    logic [2:0]  out_user;
    logic        out_last;

    logic        calm      = 1'b0;
    logic        hold_req  = 1'b0;
    logic        hold_done = 1'b0;
    int          ops_sent  = 0;
    int          mismatches;
    int          pending;
    int          beats;

    stack_queue_engine_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user),
        .o_m_axis_tlast  (out_last)
    );

    stack_queue_engine_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (in_valid),
        .i_s_tready   (in_ready),
        .i_s_tdata    (in_data),
        .i_s_tuser    (in_user),
        .i_m_tvalid   (out_valid),
        .i_m_tready   (out_ready),
        .i_m_tdata    (out_data),
        .i_m_tuser    (out_user),
        .i_m_tlast    (out_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_beats      (beats)
    );

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, one long hold-off on request, none while calm.
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            repeat (400) @(posedge clk);
            hold_done = 1'b1;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 13);
        end
    end

    // Mostly random values, with the extremes of the signed range mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Weighted opcode choice; the weights steer the store towards full or empty.
    function automatic logic [2:0] pick_op(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct) return OP_PUSH;
        if (r < push_pct + pop_pct) return OP_POP;
        r = $urandom_range(99);
        if (r < 30) return OP_PEEK;
        if (r < 60) return OP_SWAP;
        if (r < 88) return OP_PRINT;
        return OP_SPARE_A + 3'($urandom_range(2));
    endfunction

    // Offer one beat, after an occasional random gap, and wait until it is taken.
    task automatic send_beat(input logic [2:0] op, input logic [31:0] value);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 13) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_user  <= op;
        in_data  <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op <= OP_SWAP) ops_sent++;
    endtask

    // Stop offering and wait until every predicted beat has arrived and the block is quiet.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_and_settle();
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int push_pct, input int pop_pct);
        int target;
        target = ops_sent + count;
        while (ops_sent < target) send_beat(pick_op(push_pct, pop_pct), pick_value());
    endtask

    // Main stimulus.
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part in the reset mode (stack): empty cases first.
        send_beat(OP_PRINT, 32'h0000_0000);
        send_beat(OP_PEEK,  32'hFFFF_FFFF);
        send_beat(OP_POP,   32'h8000_0000);
        send_beat(OP_SWAP,  32'h7FFF_FFFF);
        send_beat(OP_PUSH,  32'h8000_0000);
        send_beat(OP_SWAP,  32'h0000_0000);
        send_beat(OP_PUSH,  32'h7FFF_FFFF);
        send_beat(OP_PUSH,  32'h0000_0000);
        send_beat(OP_PUSH,  32'hFFFF_FFFF);
        send_beat(OP_PEEK,  32'h0000_0000);
        send_beat(OP_SWAP,  32'hFFFF_FFFF);
        send_beat(OP_PRINT, 32'h0000_0000);
        send_beat(OP_SPARE_A, 32'hFFFF_FFFF);
        send_beat(OP_SPARE_B, 32'h0000_0000);
        send_beat(OP_SPARE_C, 32'h1234_5678);
        send_beat(OP_POP,   32'h0000_0000);
        send_beat(OP_PRINT, 32'h0000_0000);

        // Same checks with pushes going to the bottom.
        write_mode(1'b1);
        send_beat(OP_PUSH,  32'hA5A5_A5A5);
        send_beat(OP_PUSH,  32'h5A5A_5A5A);
        send_beat(OP_PRINT, 32'h0000_0000);
        send_beat(OP_SWAP,  32'h0000_0000);
        send_beat(OP_PEEK,  32'h0000_0000);
        send_beat(OP_PRINT, 32'h0000_0000);

        // Random part: fill past full in stack mode, then drain past empty in queue mode.
        write_mode(1'b0);
        run_phase(95, 80, 5);
        write_mode(1'b1);
        run_phase(95, 5, 75);

        // Long hold-off on the result side while beats keep being offered, then a full pause.
        write_mode(1'b0);
        hold_req <= 1'b1;
        run_phase(50, 55, 15);
        drain_and_settle();
        run_phase(45, 45, 30);

        // A stretch with no idling on either side, then random idling again.
        write_mode(1'b1);
        calm <= 1'b1;
        run_phase(50, 60, 10);
        calm <= 1'b0;
        run_phase(45, 45, 25);

        drain_and_settle();
        $display("Ran %0d operations in stack and queue modes, through full and empty stores.",
                 ops_sent);
        $display("%0d result beats were compared, including a long result-side hold-off.", beats);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sqe_pkg.sv
rtl/sqe_ram.sv
rtl/stack_queue_engine_unit.sv
test/stack_queue_engine_checker.sv
test/tb_stack_queue_engine_unit.sv
